// File: design/hvd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// hvd_pkg
// Shared constants, types and arithmetic helpers for the haversine distance
// pipeline.
// ============================================================================
package hvd_pkg;

    localparam int CORDIC_ITERATIONS = 32;
    localparam int TORAD_LAT         = 4;
    localparam int ROOT_W            = 31;
    localparam int ISQRT_STEPS       = ROOT_W;
    localparam int RAD_W             = 2 * ROOT_W - 1;
    localparam int ANG_W             = 34;

    localparam logic [63:0] PI_Q60      = 64'h3243F6A8885A308D;
    localparam logic [34:0] PI_Q33      = 35'(PI_Q60 >> 27);
    localparam logic [31:0] PI_Q30      = 32'((PI_Q60 + (64'd1 << 29)) >> 30);
    localparam logic [31:0] HALF_PI_Q30 = 32'((PI_Q60 + (64'd1 << 30)) >> 31);
    localparam logic [30:0] ONE_Q30     = 31'd1 << 30;
    localparam logic [31:0] GAIN_INV_Q30 = 32'd652032874;

    localparam logic [31:0] HALF_TURN    = 32'd180000000;
    localparam logic [31:0] FULL_TURN    = 32'd360000000;
    localparam logic [31:0] QUARTER_TURN = 32'd90000000;

    // radians = h * PI_Q33 / (2^12 * CONV_ODD), rounded
    localparam logic [31:0] CONV_HALF = 32'd1440000000;
    localparam int          CONV_SHIFT = 12;
    localparam logic [19:0] CONV_ODD  = 20'd703125;
    localparam logic [32:0] CONV_RECIP = 33'((64'd1 << 52) / 64'd703125);

    localparam logic [32:0] RADIUS_DEFAULT = 33'd6371008800;
    localparam logic        REG_RADIUS     = 1'b0;

    typedef struct packed {
        logic adv;
        logic vld;
    } t_pipe_ctl;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Q2.30 product, round to nearest, ties away from zero
    function automatic logic signed [31:0] mulq(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        logic [63:0] mag;
        logic [63:0] rnd;
        p   = 64'(a) * 64'(b);
        mag = p[63] ? 64'(-p) : 64'(p);
        rnd = (mag + (64'd1 << 29)) >> 30;
        return p[63] ? -$signed(rnd[31:0]) : $signed(rnd[31:0]);
    endfunction

endpackage

// File: design/hvd_to_rad.sv
`timescale 1ns / 1ps
// ============================================================================
// hvd_to_rad
// Converts half-microdegrees to Q2.30 radians, rounded to nearest, with an
// exact constant division by reciprocal multiply and remainder correction.
// ============================================================================
module hvd_to_rad
    import hvd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [28:0]      i_h,
    output logic                    o_vld,
    output logic signed [ANG_W-1:0] o_z
);

    logic [TORAD_LAT-1:0] r_vld;
    logic [62:0]          r_a_num;
    logic [2:0]           r_neg;
    logic [50:0]          r_b_num;
    logic [31:0]          r_b_q0;
    logic [31:0]          r_c_q0;
    logic [21:0]          r_c_rem;
    logic signed [ANG_W-1:0] r_z;

    logic [27:0] w_mag;
    logic [63:0] w_prod;
    logic [51:0] w_rem;
    logic [1:0]  w_inc;
    logic [31:0] w_q;

    always_comb begin
        w_mag  = i_h[28] ? 28'(-i_h) : i_h[27:0];
        w_prod = 64'(r_a_num[62:CONV_SHIFT+20]) * 64'(CONV_RECIP);
        w_rem  = 52'(r_b_num) - 52'(r_b_q0) * 52'(CONV_ODD);
        w_inc  = 2'(r_c_rem >= 22'(CONV_ODD)) + 2'(r_c_rem >= 22'(2 * CONV_ODD))
                 + 2'(r_c_rem >= 22'(3 * CONV_ODD));
        w_q    = r_c_q0 + 32'(w_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.adv) begin
            r_vld <= {r_vld[TORAD_LAT-2:0], i_ctl.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_a_num <= 63'(w_mag) * 63'(PI_Q33) + 63'(CONV_HALF);
            r_neg   <= {r_neg[1:0], i_h[28]};
            r_b_num <= r_a_num[62:CONV_SHIFT];
            r_b_q0  <= w_prod[63:32];
            r_c_q0  <= r_b_q0;
            r_c_rem <= w_rem[21:0];
            r_z     <= r_neg[2] ? -$signed(ANG_W'(w_q)) : $signed(ANG_W'(w_q));
        end
    end

    assign o_vld = r_vld[TORAD_LAT-1];
    assign o_z   = r_z;

endmodule

// File: design/hvd_cordic_rot.sv
`timescale 1ns / 1ps
// ============================================================================
// hvd_cordic_rot
// Rotation-mode CORDIC, one iteration per register stage; returns cosine
// and sine of a Q2.30 angle.
// ============================================================================
module hvd_cordic_rot
    import hvd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic signed [ANG_W-1:0] i_z,
    output logic                    o_vld,
    output logic signed [ANG_W-1:0] o_cos,
    output logic signed [ANG_W-1:0] o_sin
);

    localparam int N = CORDIC_ITERATIONS;

    logic signed [ANG_W-1:0] s_x [0:N];
    logic signed [ANG_W-1:0] s_y [0:N];
    logic signed [ANG_W-1:0] s_z [0:N];
    logic [N:0]              s_vld;

    assign s_x[0]   = ANG_W'(GAIN_INV_Q30);
    assign s_y[0]   = '0;
    assign s_z[0]   = i_z;
    assign s_vld[0] = i_ctl.vld;

    for (genvar g = 0; g < N; g++) begin : g_iter
        localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(g));
        logic signed [ANG_W-1:0] n_x, n_y, n_z;
        logic signed [ANG_W-1:0] r_x, r_y, r_z;
        logic                    r_vld;

        always_comb begin
            if (!s_z[g][ANG_W-1]) begin
                n_x = s_x[g] - (s_y[g] >>> g);
                n_y = s_y[g] + (s_x[g] >>> g);
                n_z = s_z[g] - ATAN;
            end else begin
                n_x = s_x[g] + (s_y[g] >>> g);
                n_y = s_y[g] - (s_x[g] >>> g);
                n_z = s_z[g] + ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign s_x[g+1]   = r_x;
        assign s_y[g+1]   = r_y;
        assign s_z[g+1]   = r_z;
        assign s_vld[g+1] = r_vld;
    end

    assign o_vld = s_vld[N] & (s_z[N] == s_z[N]);
    assign o_cos = s_x[N];
    assign o_sin = s_y[N];

endmodule

// File: design/hvd_isqrt.sv
`timescale 1ns / 1ps
// ============================================================================
// hvd_isqrt
// Integer square root, truncated, one result bit per register stage.
// ============================================================================
module hvd_isqrt
    import hvd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_pipe_ctl         i_ctl,
    input  logic [RAD_W-1:0]  i_rad,
    output logic              o_vld,
    output logic [ROOT_W-1:0] o_root
);

    localparam int N  = ISQRT_STEPS;
    localparam int VW = RAD_W + 1;

    logic [VW-1:0] s_v [0:N];
    logic [VW-1:0] s_r [0:N];
    logic [N:0]    s_vld;

    assign s_v[0]   = VW'(i_rad);
    assign s_r[0]   = '0;
    assign s_vld[0] = i_ctl.vld;

    for (genvar g = 0; g < N; g++) begin : g_step
        localparam logic [VW-1:0] BIT = VW'(1) << (2 * (N - 1 - g));
        logic [VW-1:0] n_v, n_r, w_trial;
        logic [VW-1:0] r_v, r_r;
        logic          r_vld;

        always_comb begin
            w_trial = s_r[g] + BIT;
            if (s_v[g] >= w_trial) begin
                n_v = s_v[g] - w_trial;
                n_r = (s_r[g] >> 1) + BIT;
            end else begin
                n_v = s_v[g];
                n_r = s_r[g] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_v <= n_v;
                r_r <= n_r;
            end
        end

        assign s_v[g+1]   = r_v;
        assign s_r[g+1]   = r_r;
        assign s_vld[g+1] = r_vld;
    end

    assign o_vld  = s_vld[N] & (s_v[N] == s_v[N]);
    assign o_root = s_r[N][ROOT_W-1:0];

endmodule

// File: design/hvd_cordic_vec.sv
`timescale 1ns / 1ps
// ============================================================================
// hvd_cordic_vec
// Vectoring-mode CORDIC, one iteration per register stage; returns the
// Q2.30 angle of a vector.
// ============================================================================
module hvd_cordic_vec
    import hvd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_pipe_ctl               i_ctl,
    input  logic [ROOT_W-1:0]       i_x,
    input  logic [ROOT_W-1:0]       i_y,
    output logic                    o_vld,
    output logic signed [ANG_W-1:0] o_z
);

    localparam int N = CORDIC_ITERATIONS;

    logic signed [ANG_W-1:0] s_x [0:N];
    logic signed [ANG_W-1:0] s_y [0:N];
    logic signed [ANG_W-1:0] s_z [0:N];
    logic [N:0]              s_vld;

    assign s_x[0]   = $signed(ANG_W'(i_x));
    assign s_y[0]   = $signed(ANG_W'(i_y));
    assign s_z[0]   = '0;
    assign s_vld[0] = i_ctl.vld;

    for (genvar g = 0; g < N; g++) begin : g_iter
        localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_q30(g));
        logic signed [ANG_W-1:0] n_x, n_y, n_z;
        logic signed [ANG_W-1:0] r_x, r_y, r_z;
        logic                    r_vld;

        always_comb begin
            if (!s_y[g][ANG_W-1]) begin
                n_x = s_x[g] + (s_y[g] >>> g);
                n_y = s_y[g] - (s_x[g] >>> g);
                n_z = s_z[g] + ATAN;
            end else begin
                n_x = s_x[g] - (s_y[g] >>> g);
                n_y = s_y[g] + (s_x[g] >>> g);
                n_z = s_z[g] - ATAN;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld <= 1'b0;
            end else if (i_ctl.adv) begin
                r_vld <= s_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.adv) begin
                r_x <= n_x;
                r_y <= n_y;
                r_z <= n_z;
            end
        end

        assign s_x[g+1]   = r_x;
        assign s_y[g+1]   = r_y;
        assign s_z[g+1]   = r_z;
        assign s_vld[g+1] = r_vld;
    end

    assign o_vld = s_vld[N] & (s_x[N] == s_x[N]) & (s_y[N] == s_y[N]);
    assign o_z   = s_z[N];

endmodule

// File: design/haversine_distance.sv
`timescale 1ns / 1ps
// ============================================================================
// haversine_distance
// Great-circle distance between two points given in microdegrees, in
// millimetres on a sphere of programmable radius (haversine formula).
// ============================================================================
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_from_lat, i_from_lon,
//                                                 i_to_lat, i_to_lon
//  output    out        o_out_valid / i_out_stall o_distance_mm
//  config    in         APB write, always ready   sphere_radius_mm at 0x0
//
//  One transaction enters per cycle while the output is not stalled; each
//  passes through the two CORDIC pipelines and the square-root stages.
//  Reset clears all valid bits and loads the default radius.
//  A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// ============================================================================
module haversine_distance
    import hvd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [27:0] i_from_lat,
    input  logic signed [28:0] i_from_lon,
    input  logic signed [27:0] i_to_lat,
    input  logic signed [28:0] i_to_lon,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [34:0]        o_distance_mm,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    localparam int NEG_LAT = TORAD_LAT + CORDIC_ITERATIONS + 1;

    function automatic logic signed [28:0] wrap_turn(input logic signed [29:0] d);
        logic signed [31:0] e;
        e = 32'(d);
        if (e >= $signed(HALF_TURN)) begin
            e = e - $signed(FULL_TURN);
        end else if (e < -$signed(HALF_TURN)) begin
            e = e + $signed(FULL_TURN);
        end
        return e[28:0];
    endfunction

    logic [32:0] r_radius;
    logic        w_adv;
    t_pipe_ctl   w_ctl;

    // input stage
    logic               r_s0_vld;
    logic signed [28:0] r_s0_dlat, r_s0_dlon, r_s0_h1, r_s0_h2;
    logic [27:0]        w_m1, w_m2;
    logic               w_neg1, w_neg2;
    logic [27:0]        w_f1, w_f2;

    logic [1:0] r_neg [0:NEG_LAT-1];

    always_comb begin
        w_m1   = i_from_lat[27] ? 28'(-i_from_lat) : 28'(i_from_lat);
        w_m2   = i_to_lat[27] ? 28'(-i_to_lat) : 28'(i_to_lat);
        w_neg1 = 32'(w_m1) > QUARTER_TURN;
        w_neg2 = 32'(w_m2) > QUARTER_TURN;
        w_f1   = w_neg1 ? 28'(HALF_TURN - 32'(w_m1)) : w_m1;
        w_f2   = w_neg2 ? 28'(HALF_TURN - 32'(w_m2)) : w_m2;
    end

    assign w_adv      = !o_out_valid || !i_out_stall;
    assign o_in_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (w_adv) begin
            r_s0_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_dlat <= wrap_turn(30'(i_to_lat) - 30'(i_from_lat));
            r_s0_dlon <= wrap_turn(30'(i_to_lon) - 30'(i_from_lon));
            r_s0_h1   <= $signed({w_f1[27:0], 1'b0});
            r_s0_h2   <= $signed({w_f2[27:0], 1'b0});
            r_neg[0]  <= {w_neg2, w_neg1};
            for (int k = 1; k < NEG_LAT; k++) begin
                r_neg[k] <= r_neg[k-1];
            end
        end
    end

    assign w_ctl.adv = w_adv;
    assign w_ctl.vld = r_s0_vld;

    // angles
    logic                    w_tr_vld [0:3];
    logic signed [ANG_W-1:0] w_tr_z   [0:3];
    logic signed [28:0]      w_tr_h   [0:3];

    assign w_tr_h[0] = r_s0_dlat;
    assign w_tr_h[1] = r_s0_dlon;
    assign w_tr_h[2] = r_s0_h1;
    assign w_tr_h[3] = r_s0_h2;

    logic                    w_cr_vld [0:3];
    logic signed [ANG_W-1:0] w_cr_cos [0:3];
    logic signed [ANG_W-1:0] w_cr_sin [0:3];
    t_pipe_ctl               w_tr_ctl;

    assign w_tr_ctl.adv = w_adv;
    assign w_tr_ctl.vld = w_tr_vld[0] & w_tr_vld[1] & w_tr_vld[2] & w_tr_vld[3];

    for (genvar g = 0; g < 4; g++) begin : g_ang
        hvd_to_rad u_to_rad (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_h     (w_tr_h[g]),
            .o_vld   (w_tr_vld[g]),
            .o_z     (w_tr_z[g])
        );

        hvd_cordic_rot u_rot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_tr_ctl),
            .i_z     (w_tr_z[g]),
            .o_vld   (w_cr_vld[g]),
            .o_cos   (w_cr_cos[g]),
            .o_sin   (w_cr_sin[g])
        );
    end

    // combine into a and 1 - a
    logic               r_m1_vld, r_m2_vld, r_m3_vld, r_m4_vld;
    logic signed [31:0] r_m1_hlat, r_m1_hlon, r_m1_c1, r_m1_c2;
    logic signed [31:0] r_m2_hlat, r_m2_p, r_m2_c2;
    logic signed [31:0] r_m3_hlat, r_m3_p;
    logic [RAD_W-1:0]   r_m4_a, r_m4_b;
    logic signed [33:0] w_sum;
    logic [30:0]        w_a;
    logic [1:0]         w_neg;

    assign w_neg = r_neg[NEG_LAT-1];

    always_comb begin
        w_sum = 34'(r_m3_hlat) + 34'(r_m3_p);
        if (w_sum[33]) begin
            w_a = '0;
        end else if (w_sum > $signed(34'(ONE_Q30))) begin
            w_a = ONE_Q30;
        end else begin
            w_a = w_sum[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_vld <= 1'b0;
            r_m2_vld <= 1'b0;
            r_m3_vld <= 1'b0;
            r_m4_vld <= 1'b0;
        end else if (w_adv) begin
            r_m1_vld <= w_cr_vld[0] & w_cr_vld[1] & w_cr_vld[2] & w_cr_vld[3];
            r_m2_vld <= r_m1_vld;
            r_m3_vld <= r_m2_vld;
            r_m4_vld <= r_m3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m1_hlat <= mulq(w_cr_sin[0][31:0], w_cr_sin[0][31:0]);
            r_m1_hlon <= mulq(w_cr_sin[1][31:0], w_cr_sin[1][31:0]);
            r_m1_c1   <= w_neg[0] ? -w_cr_cos[2][31:0] : w_cr_cos[2][31:0];
            r_m1_c2   <= w_neg[1] ? -w_cr_cos[3][31:0] : w_cr_cos[3][31:0];
            r_m2_hlat <= r_m1_hlat;
            r_m2_p    <= mulq(r_m1_hlon, r_m1_c1);
            r_m2_c2   <= r_m1_c2;
            r_m3_hlat <= r_m2_hlat;
            r_m3_p    <= mulq(r_m2_p, r_m2_c2);
            r_m4_a    <= {w_a, 30'b0};
            r_m4_b    <= {ONE_Q30 - w_a, 30'b0};
        end
    end

    // square roots and central angle
    t_pipe_ctl         w_sq_ctl, w_vc_ctl;
    logic              w_sqa_vld, w_sqb_vld, w_vc_vld;
    logic [ROOT_W-1:0] w_root_a, w_root_b;
    logic signed [ANG_W-1:0] w_vc_z;

    assign w_sq_ctl.adv = w_adv;
    assign w_sq_ctl.vld = r_m4_vld;

    hvd_isqrt u_sqrt_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_rad   (r_m4_a),
        .o_vld   (w_sqa_vld),
        .o_root  (w_root_a)
    );

    hvd_isqrt u_sqrt_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_sq_ctl),
        .i_rad   (r_m4_b),
        .o_vld   (w_sqb_vld),
        .o_root  (w_root_b)
    );

    assign w_vc_ctl.adv = w_adv;
    assign w_vc_ctl.vld = w_sqa_vld & w_sqb_vld;

    hvd_cordic_vec u_vec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_vc_ctl),
        .i_x     (w_root_b),
        .i_y     (w_root_a),
        .o_vld   (w_vc_vld),
        .o_z     (w_vc_z)
    );

    // scale by radius
    logic        r_f1_vld, r_f2_vld, r_out_vld;
    logic [31:0] r_f1_ang;
    logic [48:0] r_f2_hi, r_f2_lo;
    logic [34:0] r_out_dist;
    logic [31:0] w_zc;
    logic [32:0] w_ang2;
    logic [49:0] w_hi;

    always_comb begin
        if (w_vc_z[ANG_W-1]) begin
            w_zc = '0;
        end else if (w_vc_z > $signed(ANG_W'(HALF_PI_Q30))) begin
            w_zc = HALF_PI_Q30;
        end else begin
            w_zc = w_vc_z[31:0];
        end
        w_ang2 = {w_zc, 1'b0};
        w_hi   = 50'(r_f2_hi) + 50'(r_f2_lo >> 16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_f1_vld  <= w_vc_vld;
            r_f2_vld  <= r_f1_vld;
            r_out_vld <= r_f2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_f1_ang   <= (w_ang2 > 33'(PI_Q30)) ? PI_Q30 : w_ang2[31:0];
            r_f2_hi    <= 49'(r_f1_ang) * 49'(r_radius[32:16]);
            r_f2_lo    <= 49'(r_f1_ang) * 49'(r_radius[15:0]) + (49'd1 << 29);
            r_out_dist <= w_hi[48:14];
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_distance_mm = r_out_dist;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_DEFAULT;
        end else if (psel && penable && pwrite && (paddr[3] == REG_RADIUS)) begin
            r_radius <= pwdata[32:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_RADIUS) ? 64'(r_radius) : '0;

endmodule

// File: design/hvd_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// hvd_checker
// Port-level checks for haversine_distance, attached by bind.
// ============================================================================
module hvd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [34:0] o_distance_mm
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_distance_mm))
        else $error("stalled output transaction changed");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall == (o_out_valid && i_out_stall))
        else $error("input stall does not follow output stall");

    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_distance_mm <= 35'd27000000000)
        else $error("distance above half circumference bound");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);

// File: tb/haversine_distance_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// haversine_distance_chk
// Watches the input, output and register channels of haversine_distance,
// computes each expected distance in fixed point and compares every output
// transaction with the oldest one still owed.
// ============================================================================
module haversine_distance_chk (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [27:0] i_from_lat,
    input  logic signed [28:0] i_from_lon,
    input  logic signed [27:0] i_to_lat,
    input  logic signed [28:0] i_to_lon,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [34:0]        i_distance_mm,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [3:0]         i_paddr,
    input  logic [63:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_owed
);

    localparam int            STEPS     = 32;
    localparam longint        Q30_ONE   = 64'd1 << 30;
    localparam longint        ROUND_Q30 = 64'd1 << 29;
    localparam longint        PI_FULL   = 64'h3243F6A8885A308D;
    localparam longint        PI_33     = PI_FULL >>> 27;
    localparam longint        PI_30     = (PI_FULL + (64'd1 << 29)) >>> 30;
    localparam longint        HPI_30    = (PI_FULL + (64'd1 << 30)) >>> 31;
    localparam longint        KINV_30   = 652032874;
    localparam longint        TURN      = 360000000;
    localparam longint        HALF      = 180000000;
    localparam longint        QUARTER   = 90000000;
    localparam logic [32:0]   R_EARTH   = 33'd6371008800;
    localparam logic [3:0]    ADDR_RAD  = 4'd0;

    localparam longint ATAN_Q30 [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
        64'h00000001, 64'h00000000
    };

    logic [32:0] radius_mm;
    logic [34:0] distance_owed[$];

    function automatic longint q30_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) begin
            return (p + ROUND_Q30) >>> 30;
        end
        return -((-p + ROUND_Q30) >>> 30);
    endfunction

    function automatic longint wrap_udeg(input longint d);
        longint r;
        r = d % TURN;
        if (r >= HALF) begin
            r -= TURN;
        end
        if (r < -HALF) begin
            r += TURN;
        end
        return r;
    endfunction

    // half-microdegrees to Q2.30 radians
    function automatic longint half_udeg_to_rad(input longint h);
        longint unsigned m;
        longint unsigned q;
        m = (h < 0) ? -h : h;
        q = (m * longint'(PI_33) + 64'd1440000000) / 64'd2880000000;
        return (h < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic void rotate_q30(input longint z, output longint c,
                                       output longint s);
        longint x, y, dx, dy;
        x = KINV_30;
        y = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_Q30[i];
            end else begin
                x += dx; y -= dy; z += ATAN_Q30[i];
            end
        end
        c = x;
        s = y;
    endfunction

    function automatic longint vector_q30(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_Q30[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_Q30[i];
            end
        end
        return z;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) begin
            b >>= 2;
        end
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint half_sin_sq(input longint d);
        longint c, s;
        rotate_q30(half_udeg_to_rad(wrap_udeg(d)), c, s);
        return q30_mul(s, s);
    endfunction

    function automatic longint lat_cosine(input longint lat);
        longint m, c, s;
        bit     flip;
        m = wrap_udeg(lat);
        flip = 1'b0;
        if (m < 0) begin
            m = -m;
        end
        if (m > QUARTER) begin
            m = HALF - m;
            flip = 1'b1;
        end
        rotate_q30(half_udeg_to_rad(2 * m), c, s);
        return flip ? -c : c;
    endfunction

    function automatic logic [34:0] great_circle_mm(
        input logic signed [27:0] lat1, input logic signed [28:0] lon1,
        input logic signed [27:0] lat2, input logic signed [28:0] lon2,
        input logic [32:0] radius);
        longint a, b, z, ang;
        longint unsigned ang_u, rh, rl, t, hi;
        a = half_sin_sq(longint'(lat2) - longint'(lat1))
            + q30_mul(q30_mul(half_sin_sq(longint'(lon2) - longint'(lon1)),
                              lat_cosine(lat1)), lat_cosine(lat2));
        if (a < 0) begin
            a = 0;
        end
        if (a > Q30_ONE) begin
            a = Q30_ONE;
        end
        b = Q30_ONE - a;
        z = vector_q30(longint'(int_sqrt(b << 30)), longint'(int_sqrt(a << 30)));
        if (z < 0) begin
            z = 0;
        end
        if (z > HPI_30) begin
            z = HPI_30;
        end
        ang = 2 * z;
        if (ang > PI_30) begin
            ang = PI_30;
        end
        ang_u = ang;
        rh = radius >> 16;
        rl = radius & 33'hFFFF;
        t = ang_u * rl + (64'd1 << 29);
        hi = ang_u * rh + (t >> 16);
        return 35'(hi >> 14);
    endfunction

    assign o_owed = distance_owed.size();

    always @(posedge i_clk) begin
        logic [34:0] want;
        if (!i_rst_n) begin
            radius_mm <= R_EARTH;
            o_fail_count <= 0;
            distance_owed.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_RAD) begin
                radius_mm <= i_pwdata[32:0];
            end
            if (i_in_valid && !i_in_stall) begin
                distance_owed.push_back(great_circle_mm(i_from_lat, i_from_lon,
                                                         i_to_lat, i_to_lon, radius_mm));
            end
            if (i_out_valid && !i_out_stall) begin
                if (distance_owed.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected transaction: distance_mm %0d", i_distance_mm);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = distance_owed.pop_front();
                    if (want !== i_distance_mm) begin
                        if (o_fail_count < 10) begin
                            $display("distance_mm mismatch: expected %0d actual %0d",
                                     want, i_distance_mm);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: tb/haversine_distance_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// haversine_distance_tb
// Drives point pairs into haversine_distance under random input gaps and
// output stalls, across several sphere radii, and lets the checker judge
// every distance returned.
// ============================================================================
module haversine_distance_tb;

    localparam longint    R_MAX      = 64'h1FFFFFFFF;
    localparam longint    R_EARTH    = 64'd6371008800;
    localparam logic [3:0] ADDR_RAD  = 4'd0;
    localparam logic [3:0] ADDR_NONE = 4'd8;
    localparam int        DRAIN      = 150;
    localparam int        QUIET_MAX  = 20000;
    localparam int        PER_PHASE  = 180;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic signed [27:0] i_from_lat = '0;
    logic signed [28:0] i_from_lon = '0;
    logic signed [27:0] i_to_lat = '0;
    logic signed [28:0] i_to_lon = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [34:0]        o_distance_mm;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [63:0]        pwdata = '0;
    logic [63:0]        prdata;
    logic               pready;

    int fail_count;
    int owed;
    int quiet;
    bit gaps_on = 1'b1;
    bit hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    haversine_distance u_top (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall,
        .i_from_lat, .i_from_lon, .i_to_lat, .i_to_lon,
        .o_out_valid, .i_out_stall, .o_distance_mm,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    haversine_distance_chk u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall),
        .i_from_lat, .i_from_lon, .i_to_lat, .i_to_lon,
        .i_out_valid(o_out_valid), .i_out_stall, .i_distance_mm(o_distance_mm),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_owed(owed)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 70) begin
            return 0;
        end
        if (r < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, one long hold-off on request
    always @(posedge i_clk) begin
        int n;
        if (hold_req) begin
            i_out_stall <= 1'b1;
            repeat (400) @(posedge i_clk);
            hold_req = 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            n = gap_len();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_MAX) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_pair(input longint lat1, input longint lon1,
                             input longint lat2, input longint lon2);
        int n;
        i_from_lat <= 28'(lat1);
        i_from_lon <= 29'(lon1);
        i_to_lat <= 28'(lat2);
        i_to_lon <= 29'(lon2);
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        n = gap_len();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [3:0] addr, input longint value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (owed != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN) @(posedge i_clk);
    endtask

    function automatic longint rnd_lat();
        return longint'($urandom_range(0, 180000000)) - 90000000;
    endfunction

    function automatic longint rnd_lon();
        return longint'($urandom_range(0, 360000000)) - 180000000;
    endfunction

    task automatic random_pair();
        int     r;
        longint a, b;
        r = $urandom_range(0, 99);
        a = rnd_lat();
        b = rnd_lon();
        if (r < 60) begin
            send_pair(a, b, rnd_lat(), rnd_lon());
        end else if (r < 75) begin
            send_pair(a, b, a + $urandom_range(0, 2000) - 1000,
                      b + $urandom_range(0, 2000) - 1000);
        end else if (r < 85) begin
            send_pair(a, b, -a + $urandom_range(0, 20) - 10,
                      (b > 0 ? b - 180000000 : b + 180000000) + $urandom_range(0, 20) - 10);
        end else begin
            send_pair($signed(28'($urandom)), $signed(29'($urandom)),
                      $signed(28'($urandom)), $signed(29'($urandom)));
        end
    endtask

    initial begin
        longint radii[6];
        radii = '{R_EARTH, 1, R_MAX, 0, 0, R_EARTH};
        radii[4] = {$urandom_range(0, 1), 32'($urandom)};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_pair(0, 0, 0, 0);
        send_pair(45000000, 90000000, 45000000, 90000000);
        send_pair(0, 0, 0, 180000000);
        send_pair(0, -180000000, 0, 180000000);
        send_pair(90000000, 0, -90000000, 0);
        send_pair(90000000, 12345678, 90000000, -98765432);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 1, 0);
        send_pair(-90000000, -180000000, 90000000, 180000000);
        send_pair(100000000, 0, -100000000, 0);
        send_pair(-134217728, -268435456, 134217727, 268435455);
        send_pair(134217727, 268435455, -134217728, -268435456);
        send_pair(-134217728, 268435455, -134217728, -268435456);
        send_pair(30000000, 10000000, -30000000, -170000000);
        send_pair(1, 179999999, -1, -179999999);
        send_pair(45000000, 0, -45000000, 180000000);
        send_pair(89999999, 0, -89999999, 180000000);
        send_pair(51477900, -1500, 40712800, -74006000);
        settle();
        write_reg(ADDR_NONE, 64'd12345);

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) begin
                write_reg(ADDR_RAD, radii[ph]);
            end
            gaps_on = (ph != 2);
            for (int k = 0; k < PER_PHASE; k++) begin
                if (ph == 1 && k == 20) begin
                    hold_req = 1'b1;
                end
                if (ph == 3 && k == 90) begin
                    i_in_valid <= 1'b0;
                    @(posedge i_clk);
                    while (owed != 0) begin
                        @(posedge i_clk);
                    end
                end
                random_pair();
            end
            settle();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// File: files.f
design/hvd_pkg.sv
design/hvd_to_rad.sv
design/hvd_cordic_rot.sv
design/hvd_isqrt.sv
design/hvd_cordic_vec.sv
design/haversine_distance.sv
design/hvd_checker.sv
tb/haversine_distance_chk.sv
tb/haversine_distance_tb.sv
